/* design/fssh_pkg.sv */
// Shared types, constants and codes of the fan step hysteresis unit.
`timescale 1ns / 1ps

package fssh_pkg;

	// Default table geometry.
	localparam int LEVELS_DEF = 16;
	localparam int FANS_DEF   = 2;

	// Fixed field widths of the channels.
	localparam int SENSORS     = 3;
	localparam int TEMP_W      = 9;
	localparam int THR_W       = 8;
	localparam int RPM_W       = 16;
	localparam int LEVEL_IDX_W = 4;
	localparam int FAN_IDX_W   = 1;
	localparam int OPCODE_W    = 2;
	localparam int COUNT_W     = 5;

	// Level count after reset.
	localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd1;

	// A threshold of minus one marks the sensor as unused at that level.
	localparam logic [THR_W-1:0] THR_UNUSED = 8'hFF;

	typedef enum logic [OPCODE_W-1:0] {
		OP_LOAD_ON  = 2'd0,
		OP_LOAD_OFF = 2'd1,
		OP_LOAD_RPM = 2'd2,
		OP_SAMPLE   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		DIR_NONE,
		DIR_DOWN,
		DIR_UP
	} walk_dir_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_RPM_RD,
		ST_RESULT
	} state_t;

	typedef logic signed [TEMP_W-1:0] temp_t;
	typedef temp_t [SENSORS-1:0] temp_vec_t;
	typedef logic [SENSORS-1:0][THR_W-1:0] thr_vec_t;

	// One threshold table row: on and off thresholds of every sensor.
	typedef struct packed {
		thr_vec_t on_th;
		thr_vec_t off_th;
	} thr_entry_t;

	// Outcome of comparing the sample against the row just read.
	typedef struct packed {
		logic down_ok;
		logic up_ok;
	} thr_status_t;

endpackage

/* design/fssh_ifs.sv */
// Channel interfaces of the fan step hysteresis unit.
`timescale 1ns / 1ps

// Command channel: table loads and temperature samples.
interface fssh_in_if import fssh_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [OPCODE_W-1:0]     opcode;
	logic [LEVEL_IDX_W-1:0]  level_index;
	logic [FAN_IDX_W-1:0]    fan_index;
	logic signed [TEMP_W-1:0] temp_io;
	logic signed [TEMP_W-1:0] cpu_temp;
	logic signed [TEMP_W-1:0] board_temp;
	logic [RPM_W-1:0]        rpm_value;

	modport source (
		output valid, opcode, level_index, fan_index, temp_io, cpu_temp, board_temp,
			rpm_value,
		input  ready
	);
	modport sink (
		input  valid, opcode, level_index, fan_index, temp_io, cpu_temp, board_temp,
			rpm_value,
		output ready
	);
endinterface

// Result channel: rpm goal and current level.
interface fssh_out_if import fssh_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [RPM_W-1:0]       rpm_goal;
	logic [LEVEL_IDX_W-1:0] fan_level;

	modport source (output valid, rpm_goal, fan_level, input ready);
	modport sink (input valid, rpm_goal, fan_level, output ready);
endinterface

// Configuration channel: number of loaded levels.
interface fssh_cfg_if import fssh_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] level_count;

	modport source (output valid, level_count, input ready);
	modport sink (input valid, level_count, output ready);
endinterface

/* design/fssh_thr_mem.sv */
// Threshold table memory with the per-row hysteresis compare.
`timescale 1ns / 1ps

module fssh_thr_mem import fssh_pkg::*; #(
	parameter int LEVELS = LEVELS_DEF,
	localparam int LVL_W = $clog2(LEVELS)
) (
	input  logic              clk,
	input  logic              wr_on,
	input  logic              wr_off,
	input  logic [LVL_W-1:0]  wr_addr,
	input  thr_vec_t          wr_data,
	input  logic              rd_en,
	input  logic [LVL_W-1:0]  rd_addr,
	input  temp_vec_t         temps,
	output thr_status_t       status
);

	thr_entry_t mem_q [LEVELS];
	thr_entry_t rd_q;

	// Row write with separate enables for the on and off halves; registered read.
	always_ff @(posedge clk) begin
		if (wr_on) begin
			mem_q[wr_addr].on_th <= wr_data;
		end
		if (wr_off) begin
			mem_q[wr_addr].off_th <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// Down is allowed when every used sensor sits at or below its off threshold.
	// Up is requested when any used sensor reaches its on threshold.
	always_comb begin
		status.down_ok = 1'b1;
		status.up_ok   = 1'b0;
		for (int j = 0; j < SENSORS; j++) begin
			if (rd_q.off_th[j] != THR_UNUSED &&
					$signed(temps[j]) > $signed(rd_q.off_th[j])) begin
				status.down_ok = 1'b0;
			end
			if (rd_q.on_th[j] != THR_UNUSED &&
					$signed(temps[j]) >= $signed(rd_q.on_th[j])) begin
				status.up_ok = 1'b1;
			end
		end
	end

endmodule

/* design/fssh_rpm_mem.sv */
// Target rpm memory, one word per level and fan.
`timescale 1ns / 1ps

module fssh_rpm_mem import fssh_pkg::*; #(
	parameter int LEVELS = LEVELS_DEF,
	parameter int FANS = FANS_DEF,
	localparam int DEPTH = LEVELS * FANS,
	localparam int RPM_AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [RPM_AW-1:0] wr_addr,
	input  logic [RPM_W-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [RPM_AW-1:0] rd_addr,
	output logic [RPM_W-1:0]  rd_data
);

	logic [RPM_W-1:0] mem_q [DEPTH];
	logic [RPM_W-1:0] rd_q;

	// Single write port, single registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

/* design/fssh_ctrl.sv */
// Sequencer: takes commands, walks the threshold table and builds the result.
`timescale 1ns / 1ps

module fssh_ctrl import fssh_pkg::*; #(
	parameter int LEVELS = LEVELS_DEF,
	parameter int FANS = FANS_DEF,
	localparam int LVL_W = $clog2(LEVELS),
	localparam int CNT_W = $clog2(LEVELS + 1),
	localparam int RPM_AW = $clog2(LEVELS * FANS)
) (
	input  logic              clk,
	input  logic              arst_n,
	fssh_cfg_if.sink          cfg,
	fssh_in_if.sink           cmd,
	fssh_out_if.source        result,
	// Threshold memory
	output logic              thr_wr_on,
	output logic              thr_wr_off,
	output logic [LVL_W-1:0]  thr_wr_addr,
	output thr_vec_t          thr_wr_data,
	output logic              thr_rd_en,
	output logic [LVL_W-1:0]  thr_rd_addr,
	output temp_vec_t         temps,
	input  thr_status_t       thr_status,
	// Rpm memory
	output logic              rpm_wr_en,
	output logic [RPM_AW-1:0] rpm_wr_addr,
	output logic [RPM_W-1:0]  rpm_wr_data,
	output logic              rpm_rd_en,
	output logic [RPM_AW-1:0] rpm_rd_addr,
	input  logic [RPM_W-1:0]  rpm_rd_data
);

	state_t                 state_q, state_d;
	walk_dir_t              dir_q, dir_in;
	opcode_t                op_q, cmd_op;
	logic [FAN_IDX_W-1:0]   fan_q;
	temp_vec_t              temps_q, prev_q, cmd_temps;
	logic [CNT_W-1:0]       walk_q, walk_d, walk_step, cnt, level_fin;
	logic [LVL_W-1:0]       level_q;
	logic [COUNT_W-1:0]     level_count_q;
	logic                   out_valid_q;
	logic [RPM_W-1:0]       rpm_q;
	logic [LEVEL_IDX_W-1:0] fan_level_q;
	logic                   cmd_acc, lvl_in_range, fell, rose, walk_stop;
	logic                   level_load, out_load;

	assign cmd_acc   = cmd.valid && cmd.ready;
	assign cmd_op    = opcode_t'(cmd.opcode);
	assign cmd_temps = {cmd.board_temp, cmd.cpu_temp, cmd.temp_io};

	// Configuration is never back-pressured.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_count_q <= COUNT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			level_count_q <= cfg.level_count;
		end
	end

	// Effective number of loaded levels: zero acts as one, clipped to the table size.
	always_comb begin
		if (level_count_q == '0) begin
			cnt = CNT_W'(1);
		end else if (int'(level_count_q) > LEVELS) begin
			cnt = CNT_W'(LEVELS);
		end else begin
			cnt = CNT_W'(level_count_q);
		end
	end

	// Table writes happen in the cycle a load transaction is accepted.
	// Reads are issued only when a sample is accepted or after the block leaves idle, so no access overlaps a write.
	assign lvl_in_range = int'(cmd.level_index) < LEVELS;
	assign thr_wr_on    = cmd_acc && cmd_op == OP_LOAD_ON && lvl_in_range;
	assign thr_wr_off   = cmd_acc && cmd_op == OP_LOAD_OFF && lvl_in_range;
	assign thr_wr_addr  = LVL_W'(cmd.level_index);
	assign rpm_wr_en    = cmd_acc && cmd_op == OP_LOAD_RPM && lvl_in_range &&
		int'(cmd.fan_index) < FANS;
	assign rpm_wr_addr  = RPM_AW'(int'(cmd.level_index) * FANS + int'(cmd.fan_index));
	assign rpm_wr_data  = cmd.rpm_value;

	// Thresholds keep the low eight bits of each temperature field.
	always_comb begin
		for (int j = 0; j < SENSORS; j++) begin
			thr_wr_data[j] = cmd_temps[j][THR_W-1:0];
		end
	end

	// Walk direction from the new sample against the stored temperatures.
	always_comb begin
		fell = 1'b0;
		rose = 1'b0;
		for (int j = 0; j < SENSORS; j++) begin
			if ($signed(cmd_temps[j]) < $signed(prev_q[j])) begin
				fell = 1'b1;
			end
			if ($signed(cmd_temps[j]) > $signed(prev_q[j])) begin
				rose = 1'b1;
			end
		end
		if (fell) begin
			dir_in = DIR_DOWN;
		end else if (rose) begin
			dir_in = DIR_UP;
		end else begin
			dir_in = DIR_NONE;
		end
	end

	// One table row per cycle: the row of walk_q is in the memory output register.
	always_comb begin
		case (dir_q)
			DIR_DOWN: begin
				walk_stop = walk_q == '0 || !thr_status.down_ok;
				walk_step = walk_q - CNT_W'(1);
			end
			DIR_UP: begin
				walk_stop = walk_q >= cnt || !thr_status.up_ok;
				walk_step = walk_q + CNT_W'(1);
			end
			default: begin
				walk_stop = 1'b1;
				walk_step = walk_q;
			end
		endcase
	end

	// A sample clamps the walked level into the loaded range; a load keeps the level.
	assign level_fin = (op_q == OP_SAMPLE && walk_q >= cnt) ? cnt - CNT_W'(1) : walk_q;
	assign rpm_rd_addr = RPM_AW'(int'(level_fin) * FANS + int'(fan_q));

	// Next state and memory strobes.
	always_comb begin
		state_d     = state_q;
		walk_d      = walk_q;
		thr_rd_en   = 1'b0;
		thr_rd_addr = LVL_W'(walk_q);
		rpm_rd_en   = 1'b0;
		level_load  = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				thr_rd_addr = level_q;
				if (cmd_acc) begin
					if (cmd_op == OP_SAMPLE) begin
						thr_rd_en = 1'b1;
						state_d   = ST_WALK;
					end else begin
						state_d = ST_RPM_RD;
					end
				end
			end
			ST_WALK: begin
				if (walk_stop) begin
					state_d = ST_RPM_RD;
				end else begin
					walk_d      = walk_step;
					thr_rd_en   = 1'b1;
					thr_rd_addr = LVL_W'(walk_step);
				end
			end
			ST_RPM_RD: begin
				rpm_rd_en  = 1'b1;
				level_load = 1'b1;
				state_d    = ST_RESULT;
			end
			ST_RESULT: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			level_q     <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (level_load) begin
				level_q <= LVL_W'(level_fin);
				if (op_q == OP_SAMPLE) begin
					prev_q <= temps_q;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Transaction payload and walk position.
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			op_q    <= cmd_op;
			fan_q   <= cmd.fan_index;
			temps_q <= cmd_temps;
			dir_q   <= dir_in;
			walk_q  <= CNT_W'(level_q);
		end else if (state_q == ST_WALK) begin
			walk_q <= walk_d;
		end
		if (out_load) begin
			rpm_q       <= (int'(fan_q) < FANS) ? rpm_rd_data : '0;
			fan_level_q <= LEVEL_IDX_W'(level_q);
		end
	end

	assign temps            = temps_q;
	assign cmd.ready        = state_q == ST_IDLE;
	assign result.valid     = out_valid_q;
	assign result.rpm_goal  = rpm_q;
	assign result.fan_level = fan_level_q;

endmodule

/* design/multi_sensor_fan_step_hysteresis_unit.sv */
// A load transaction passes through the rpm read and result states before its result is
// registered; a sample first walks the threshold table, at most the table size in levels.
// One transaction is in work at a time; the next is accepted once the result has entered
// the output register, which waits while an earlier result is still stalled.
// Reset clears the level, stored temperatures and control; level_count resets to 1.
// Table contents are not cleared and must be written before they are read.
`timescale 1ns / 1ps

module multi_sensor_fan_step_hysteresis_unit import fssh_pkg::*; #(
	parameter int LEVELS = LEVELS_DEF,
	parameter int FANS = FANS_DEF,
	localparam int LVL_W = $clog2(LEVELS),
	localparam int RPM_AW = $clog2(LEVELS * FANS)
) (
	input  logic       clk,
	input  logic       arst_n,
	fssh_cfg_if.sink   cfg,
	fssh_in_if.sink    cmd,
	fssh_out_if.source result
);

	logic              thr_wr_on, thr_wr_off, thr_rd_en;
	logic [LVL_W-1:0]  thr_wr_addr, thr_rd_addr;
	thr_vec_t          thr_wr_data;
	temp_vec_t         temps;
	thr_status_t       thr_status;
	logic              rpm_wr_en, rpm_rd_en;
	logic [RPM_AW-1:0] rpm_wr_addr, rpm_rd_addr;
	logic [RPM_W-1:0]  rpm_wr_data, rpm_rd_data;

	// Sequencer.
	fssh_ctrl #(
		.LEVELS (LEVELS),
		.FANS   (FANS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.result      (result),
		.thr_wr_on   (thr_wr_on),
		.thr_wr_off  (thr_wr_off),
		.thr_wr_addr (thr_wr_addr),
		.thr_wr_data (thr_wr_data),
		.thr_rd_en   (thr_rd_en),
		.thr_rd_addr (thr_rd_addr),
		.temps       (temps),
		.thr_status  (thr_status),
		.rpm_wr_en   (rpm_wr_en),
		.rpm_wr_addr (rpm_wr_addr),
		.rpm_wr_data (rpm_wr_data),
		.rpm_rd_en   (rpm_rd_en),
		.rpm_rd_addr (rpm_rd_addr),
		.rpm_rd_data (rpm_rd_data)
	);

	// Threshold table.
	fssh_thr_mem #(
		.LEVELS (LEVELS)
	) u_thr_mem (
		.clk     (clk),
		.wr_on   (thr_wr_on),
		.wr_off  (thr_wr_off),
		.wr_addr (thr_wr_addr),
		.wr_data (thr_wr_data),
		.rd_en   (thr_rd_en),
		.rd_addr (thr_rd_addr),
		.temps   (temps),
		.status  (thr_status)
	);

	// Rpm table.
	fssh_rpm_mem #(
		.LEVELS (LEVELS),
		.FANS   (FANS)
	) u_rpm_mem (
		.clk     (clk),
		.wr_en   (rpm_wr_en),
		.wr_addr (rpm_wr_addr),
		.wr_data (rpm_wr_data),
		.rd_en   (rpm_rd_en),
		.rd_addr (rpm_rd_addr),
		.rd_data (rpm_rd_data)
	);

endmodule

/* design/fssh_checker.sv */
// Port-level checks of the fan step hysteresis unit and their binding.
`timescale 1ns / 1ps

module fssh_checker import fssh_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cmd_valid,
	input logic                   cmd_ready,
	input logic                   res_valid,
	input logic                   res_ready,
	input logic [RPM_W-1:0]       rpm_goal,
	input logic [LEVEL_IDX_W-1:0] fan_level
);

	logic [1:0] pend_q;
	logic       cmd_acc, res_acc;

	assign cmd_acc = cmd_valid && cmd_ready;
	assign res_acc = res_valid && res_ready;

	// Transactions accepted whose result has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(cmd_acc) - 2'(res_acc);
		end
	end

	// A waiting result stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn while stalled");

	// A waiting result keeps its payload.
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(rpm_goal) && $stable(fan_level))
		else $error("result payload changed while stalled");

	// The block works on one transaction at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> !cmd_ready)
		else $error("command accepted twice in a row");

	// Every offered result belongs to an accepted transaction.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pend_q != 2'd0)
		else $error("result without a pending transaction");

	// At most one result waiting and one transaction in work.
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many transactions outstanding");

endmodule

bind multi_sensor_fan_step_hysteresis_unit fssh_checker u_fssh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.rpm_goal  (result.rpm_goal),
	.fan_level (result.fan_level)
);
